### hw/rtl/clocked_sensor_frame_decoder_defines.svh
// Assertion macros for the sensor frame decoder.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef CLOCKED_SENSOR_FRAME_DECODER_DEFINES_SVH
`define CLOCKED_SENSOR_FRAME_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csfd assertion failed");

`endif

### hw/rtl/csfd_pkg.sv
// Shared types and constants for the sensor frame decoder.
// No dependencies.
`default_nettype none

package csfd_pkg;

    localparam int unsigned FRAME_BYTES = 5;
    localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
    localparam int unsigned CNT_W       = $clog2(FRAME_BITS + 1);

    localparam logic [7:0] TERMINATOR  = 8'h0D;
    localparam logic [7:0] GAP_RESET   = 8'd2;

    localparam int unsigned S_TDATA_W  = 40;  // time_ms + data_bit, byte padded
    localparam int unsigned M_TDATA_W  = 32;  // frame_valid + type + value, byte padded

    typedef struct packed {
        logic [31:0] time_ms;
        logic        data_bit;
    } in_item_t;

endpackage

`default_nettype wire

### hw/rtl/csfd_in_stage.sv
// Input register for the sensor frame decoder: holds one accepted bit.
// Depends on csfd_pkg.
`default_nettype none

module csfd_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire csfd_pkg::in_item_t s_item,
    output logic                   item_valid,
    output csfd_pkg::in_item_t     item,
    input  wire logic              item_take
);
    import csfd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/csfd_frame_core.sv
// Frame state, gap detection, checksum check and result register.
// Depends on csfd_pkg.
`default_nettype none

module csfd_frame_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    input  wire logic               item_valid,
    input  wire csfd_pkg::in_item_t item,
    output logic                    item_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    frame_done,
    output logic                    frame_valid,
    output logic [7:0]              reading_type,
    output logic [15:0]             reading_value
);
    import csfd_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BITS);

    logic [7:0]             gap_limit_reg;
    logic [CNT_W-1:0]       bit_count_reg,  bit_count_next;
    logic [FRAME_BITS-1:0]  frame_sr_reg,   frame_sr_next;
    logic [31:0]            last_time_reg;
    logic                   held_valid_reg, held_valid_next;
    logic [7:0]             held_type_reg,  held_type_next;
    logic [15:0]            held_value_reg, held_value_next;
    logic                   out_valid_reg,  out_valid_next;
    logic                   done_reg,       done_next;

    logic [31:0]            gap;
    logic [CNT_W-1:0]       cnt_eff;
    logic [7:0]             sum;
    logic                   frame_ok;

    assign item_take = item_valid && (!out_valid_reg || out_ready);

    always_comb begin
        gap     = item.time_ms - last_time_reg;
        cnt_eff = (gap > {24'd0, gap_limit_reg}) ? '0 : bit_count_reg;

        bit_count_next  = cnt_eff;
        frame_sr_next   = frame_sr_reg;
        done_next       = 1'b0;
        held_valid_next = held_valid_reg;
        held_type_next  = held_type_reg;
        held_value_next = held_value_reg;

        // Shift register: first byte ends up in the top eight bits.
        if (cnt_eff < FULL_CNT) begin
            frame_sr_next  = {frame_sr_reg[FRAME_BITS-2:0], item.data_bit};
            bit_count_next = cnt_eff + CNT_W'(1);
        end

        sum      = frame_sr_next[39:32] + frame_sr_next[31:24] + frame_sr_next[23:16];
        frame_ok = (sum == frame_sr_next[15:8]) && (frame_sr_next[7:0] == TERMINATOR);

        if ((cnt_eff < FULL_CNT) && (bit_count_next == FULL_CNT)) begin
            done_next       = 1'b1;
            held_valid_next = frame_ok;
            if (frame_ok) begin
                held_type_next  = frame_sr_next[39:32];
                held_value_next = frame_sr_next[31:16];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit_reg  <= GAP_RESET;
            bit_count_reg  <= '0;
            frame_sr_reg   <= '0;
            last_time_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_type_reg  <= '0;
            held_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                gap_limit_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            if (item_take) begin
                bit_count_reg  <= bit_count_next;
                frame_sr_reg   <= frame_sr_next;
                last_time_reg  <= item.time_ms;
                held_valid_reg <= held_valid_next;
                held_type_reg  <= held_type_next;
                held_value_reg <= held_value_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            done_reg <= done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_done    = done_reg;
    assign frame_valid   = held_valid_reg;
    assign reading_type  = held_type_reg;
    assign reading_value = held_value_reg;

endmodule

`default_nettype wire

### hw/rtl/clocked_sensor_frame_decoder.sv
// Sensor frame decoder: collects sampled bits into 40-bit frames and checks them.
// Top level; depends on csfd_pkg, csfd_in_stage, csfd_frame_core and the defines header.
//
// Usage:
//   s_axis: one transfer per sampled data bit with its millisecond timestamp.
//   m_axis: exactly one transfer per input bit. tlast marks the bit that
//     completed a 40-bit frame; tdata carries the check result of the last
//     completed frame and the type and value of the last valid frame.
//   cfg: write gap_limit_ms with cfg_wr_en; write only while the block is idle.
// Path: a bit's result reaches m_axis from its s_axis transfer through the input
//   register, then the result register.
// Throughput: one bit per cycle while m_axis_tready is high; the frame state (bit
//   counter, timestamp, shift register) is updated once per taken bit.
// Stall: while m_axis_tready is low the result holds, one more bit is taken
//   into the input register, then s_axis_tready drops.
// Reset: gap limit 2 ms, bit counter, timestamp and held reading cleared;
//   both channels empty.
`default_nettype none

`include "clocked_sensor_frame_decoder_defines.svh"

module clocked_sensor_frame_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [7:0]                        cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] time_ms, [32] data_bit, [39:33] zero
    input  wire logic [csfd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] frame_valid, [8:1] reading_type, [24:9] reading_value, [31:25] zero
    output logic [csfd_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // frame_done
    output logic                                   m_axis_tlast
);
    import csfd_pkg::*;

    in_item_t    s_item;
    in_item_t    item;
    logic        item_valid;
    logic        item_take;
    logic        frame_valid;
    logic [7:0]  reading_type;
    logic [15:0] reading_value;

    assign s_item.time_ms  = s_axis_tdata[31:0];
    assign s_item.data_bit = s_axis_tdata[32];

    csfd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    csfd_frame_core u_frame_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .frame_done    (m_axis_tlast),
        .frame_valid   (frame_valid),
        .reading_type  (reading_type),
        .reading_value (reading_value)
    );

    assign m_axis_tdata = {7'd0, reading_value, reading_type, frame_valid};

    // Input only stalls behind a held result.
    `CSFD_ASSERT_NOW(a_stall_needs_result, !s_axis_tready, m_axis_tvalid)
    // A queued bit reaches an empty result register in the next cycle.
    `CSFD_ASSERT_NEXT(a_queued_bit_advances, item_valid && !m_axis_tvalid, m_axis_tvalid)
    // A bit is only processed when it is held in the input register.
    `CSFD_ASSERT_NOW(a_take_needs_item, item_take, item_valid)

endmodule

`default_nettype wire
